>>> rtl/afv_pkg.sv
// Shared types, constants and helpers for the artifact frame validator.
// Depends on nothing; the top level refers to it by scoped names and the bench files import it.
`default_nettype none

package afv_pkg;

  localparam int HDR_BASE_SIZE = 44;
  localparam int HDR_EXT_SIZE  = 16;
  localparam int HDR_FULL_SIZE = HDR_BASE_SIZE + HDR_EXT_SIZE;
  localparam int HDR_ADDR_W    = $clog2(HDR_FULL_SIZE);
  localparam int SIG_LEN       = 8;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

  localparam logic [3:0] FLD_MAJOR    = 4'd0;
  localparam logic [3:0] FLD_MINOR    = 4'd1;
  localparam logic [3:0] FLD_LAYERS   = 4'd2;
  localparam logic [3:0] FLD_CTX      = 4'd3;
  localparam logic [3:0] FLD_TOKENS   = 4'd4;
  localparam logic [3:0] FLD_TYPEK    = 4'd5;
  localparam logic [3:0] FLD_TYPEV    = 4'd6;
  localparam logic [3:0] FLD_FLAGS    = 4'd7;
  localparam logic [3:0] FLD_LASTTOK  = 4'd8;
  localparam logic [3:0] FLD_VTRANS   = 4'd9;
  localparam logic [3:0] FLD_MLA      = 4'd10;
  localparam logic [3:0] FLD_RESERVED = 4'd11;
  localparam logic [3:0] FLD_FPRINT   = 4'd12;
  localparam logic [3:0] FLD_PAYBYTES = 4'd13;
  localparam logic [3:0] FLD_CRC      = 4'd14;
  localparam logic [3:0] SEQ_STATUS   = 4'd15;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_FIELD   = 2'd1,
    KIND_STATUS  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_HDR_SHORT   = 3'd1,
    ST_BAD_MAGIC   = 3'd2,
    ST_EXT_SHORT   = 3'd3,
    ST_PAY_SHORT   = 3'd4,
    ST_CRC_BAD     = 3'd5
  } status_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic [3:0]  field_index;
    logic [63:0] field_value;
    status_t     status;
    logic        last;
  } out_res_t;

  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h4B;
      3'd1:    b = 8'h56;
      3'd2:    b = 8'h41;
      3'd3:    b = 8'h52;
      3'd4:    b = 8'h54;
      3'd5:    b = 8'h49;
      3'd6:    b = 8'h46;
      default: b = 8'h31;
    endcase
    return b;
  endfunction

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int j = 0; j < 8; j++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/afv_in_if.sv
// Input byte channel of the artifact frame validator.
// Depends on nothing beyond the language.
`default_nettype none

interface afv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

`default_nettype wire

>>> rtl/afv_out_if.sv
// Result channel of the artifact frame validator.
// Depends on nothing beyond the language.
`default_nettype none

interface afv_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  payload_byte;
  logic [3:0]  field_index;
  logic [63:0] field_value;
  logic [2:0]  status;
  logic        last;

  modport source (output valid, output kind, output payload_byte, output field_index,
                  output field_value, output status, output last, input ready);
  modport sink (input valid, input kind, input payload_byte, input field_index,
                input field_value, input status, input last, output ready);
endinterface

`default_nettype wire

>>> rtl/artifact_frame_validator.sv
// Top level of the artifact frame validator: header capture, payload CRC-32, result sequencing.
// Depends on afv_pkg, afv_in_if and afv_out_if.
`default_nettype none

// Bytes of a buffer enter one per cycle while results are taken; each payload byte
// leaves as one transaction through a single output register, unless the signature
// mismatched. The final byte of a buffer holds off input through status evaluation
// and then while the 15 header fields (on success) and the status are sent, one
// result at a time. The 60-byte header store is plain flip-flops read at fixed
// offsets; the CRC takes one payload byte per cycle while input bytes are accepted.
module artifact_frame_validator (
  input  wire logic clk,
  input  wire logic rst_n,
  afv_in_if.sink    in_ch,
  afv_out_if.source out_ch
);

  typedef enum logic [2:0] {
    PH_RUN  = 3'b001,
    PH_EVAL = 3'b010,
    PH_EMIT = 3'b100
  } phase_t;

  localparam logic [63:0] BASE64 = 64'(afv_pkg::HDR_BASE_SIZE);
  localparam logic [63:0] FULL64 = 64'(afv_pkg::HDR_FULL_SIZE);
  localparam logic [63:0] SIG64  = 64'(afv_pkg::SIG_LEN);

  logic [7:0]  hdr_mem_r [afv_pkg::HDR_FULL_SIZE];
  logic [63:0] pos_r, pos_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic        mis_r, mis_nxt;
  phase_t      ph_r, ph_nxt;
  afv_pkg::status_t st_r, st_nxt;
  logic [3:0]  seq_r, seq_nxt;
  logic        ov_r, ov_nxt;
  afv_pkg::out_res_t ores_r, ores_nxt;

  logic        slot_free, in_acc, has_ext, hdr_wr, in_pay;
  logic [63:0] hdr_len, pay_len, rel_pos;
  logic [31:0] want_crc, got_crc;
  logic [63:0] fld_val;
  afv_pkg::status_t eval_st;

  assign slot_free   = !ov_r || out_ch.ready;
  assign in_ch.ready = (ph_r == PH_RUN) && slot_free;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign has_ext  = {hdr_mem_r[11], hdr_mem_r[10]} != 16'd0;
  assign hdr_len  = has_ext ? FULL64 : BASE64;
  assign pay_len  = {hdr_mem_r[39], hdr_mem_r[38], hdr_mem_r[37], hdr_mem_r[36],
                     hdr_mem_r[35], hdr_mem_r[34], hdr_mem_r[33], hdr_mem_r[32]};
  assign want_crc = {hdr_mem_r[43], hdr_mem_r[42], hdr_mem_r[41], hdr_mem_r[40]};
  assign rel_pos  = pos_r - hdr_len;
  assign hdr_wr   = (pos_r < FULL64) && ((pos_r < BASE64) || has_ext);
  assign in_pay   = (pos_r >= hdr_len) && (rel_pos < pay_len);
  assign got_crc  = (pay_len != 64'd0) ? (crc_r ^ afv_pkg::CRC_ONES) : 32'd0;

  always_comb begin
    if (pos_r < BASE64) begin
      eval_st = afv_pkg::ST_HDR_SHORT;
    end else if (mis_r) begin
      eval_st = afv_pkg::ST_BAD_MAGIC;
    end else if (has_ext && (pos_r < FULL64)) begin
      eval_st = afv_pkg::ST_EXT_SHORT;
    end else if (rel_pos < pay_len) begin
      eval_st = afv_pkg::ST_PAY_SHORT;
    end else if (got_crc != want_crc) begin
      eval_st = afv_pkg::ST_CRC_BAD;
    end else begin
      eval_st = afv_pkg::ST_OK;
    end
  end

  always_comb begin
    case (seq_r)
      afv_pkg::FLD_MAJOR:    fld_val = {48'd0, hdr_mem_r[9], hdr_mem_r[8]};
      afv_pkg::FLD_MINOR:    fld_val = {48'd0, hdr_mem_r[11], hdr_mem_r[10]};
      afv_pkg::FLD_LAYERS:   fld_val = {32'd0, hdr_mem_r[15], hdr_mem_r[14],
                                        hdr_mem_r[13], hdr_mem_r[12]};
      afv_pkg::FLD_CTX:      fld_val = {32'd0, hdr_mem_r[19], hdr_mem_r[18],
                                        hdr_mem_r[17], hdr_mem_r[16]};
      afv_pkg::FLD_TOKENS:   fld_val = {32'd0, hdr_mem_r[23], hdr_mem_r[22],
                                        hdr_mem_r[21], hdr_mem_r[20]};
      afv_pkg::FLD_TYPEK:    fld_val = {48'd0, hdr_mem_r[25], hdr_mem_r[24]};
      afv_pkg::FLD_TYPEV:    fld_val = {48'd0, hdr_mem_r[27], hdr_mem_r[26]};
      afv_pkg::FLD_FLAGS:    fld_val = {32'd0, hdr_mem_r[31], hdr_mem_r[30],
                                        hdr_mem_r[29], hdr_mem_r[28]};
      afv_pkg::FLD_LASTTOK:  fld_val = has_ext ? {32'd0, hdr_mem_r[47], hdr_mem_r[46],
                                                  hdr_mem_r[45], hdr_mem_r[44]}
                                               : {32'd0, afv_pkg::CRC_ONES};
      afv_pkg::FLD_VTRANS:   fld_val = has_ext ? {56'd0, hdr_mem_r[48]} : 64'd0;
      afv_pkg::FLD_MLA:      fld_val = has_ext ? {56'd0, hdr_mem_r[49]} : 64'd0;
      afv_pkg::FLD_RESERVED: fld_val = has_ext ? {48'd0, hdr_mem_r[51], hdr_mem_r[50]}
                                               : 64'd0;
      afv_pkg::FLD_FPRINT:   fld_val = has_ext ? {hdr_mem_r[59], hdr_mem_r[58],
                                                  hdr_mem_r[57], hdr_mem_r[56],
                                                  hdr_mem_r[55], hdr_mem_r[54],
                                                  hdr_mem_r[53], hdr_mem_r[52]}
                                               : 64'd0;
      afv_pkg::FLD_PAYBYTES: fld_val = pay_len;
      afv_pkg::FLD_CRC:      fld_val = {32'd0, want_crc};
      default:               fld_val = 64'd0;
    endcase
  end

  always_comb begin
    pos_nxt  = pos_r;
    crc_nxt  = crc_r;
    mis_nxt  = mis_r;
    ph_nxt   = ph_r;
    st_nxt   = st_r;
    seq_nxt  = seq_r;
    ov_nxt   = ov_r && !out_ch.ready;
    ores_nxt = ores_r;
    case (ph_r)
      PH_RUN: begin
        if (in_acc) begin
          if ((pos_r < SIG64) && (in_ch.data_byte != afv_pkg::sig_byte(pos_r[2:0]))) begin
            mis_nxt = 1'b1;
          end
          if (in_pay) begin
            crc_nxt = afv_pkg::crc_byte(crc_r, in_ch.data_byte);
            if (!mis_r) begin
              ov_nxt                = 1'b1;
              ores_nxt              = '0;
              ores_nxt.kind         = afv_pkg::KIND_PAYLOAD;
              ores_nxt.payload_byte = in_ch.data_byte;
            end
          end
          if (pos_r != '1) begin
            pos_nxt = pos_r + 64'd1;
          end
          if (in_ch.end_of_buffer) begin
            ph_nxt = PH_EVAL;
          end
        end
      end
      PH_EVAL: begin
        st_nxt  = eval_st;
        seq_nxt = (eval_st == afv_pkg::ST_OK) ? afv_pkg::FLD_MAJOR : afv_pkg::SEQ_STATUS;
        ph_nxt  = PH_EMIT;
      end
      PH_EMIT: begin
        if (slot_free) begin
          ov_nxt   = 1'b1;
          ores_nxt = '0;
          if (seq_r == afv_pkg::SEQ_STATUS) begin
            ores_nxt.kind   = afv_pkg::KIND_STATUS;
            ores_nxt.status = st_r;
            ores_nxt.last   = 1'b1;
            ph_nxt          = PH_RUN;
            pos_nxt         = '0;
            crc_nxt         = afv_pkg::CRC_ONES;
            mis_nxt         = 1'b0;
          end else begin
            ores_nxt.kind        = afv_pkg::KIND_FIELD;
            ores_nxt.field_index = seq_r;
            ores_nxt.field_value = fld_val;
            seq_nxt = (seq_r == afv_pkg::FLD_CRC) ? afv_pkg::SEQ_STATUS : seq_r + 4'd1;
          end
        end
      end
      default: ph_nxt = PH_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      crc_r <= afv_pkg::CRC_ONES;
      mis_r <= 1'b0;
      ph_r  <= PH_RUN;
      st_r  <= afv_pkg::ST_OK;
      seq_r <= afv_pkg::FLD_MAJOR;
      ov_r  <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      crc_r <= crc_nxt;
      mis_r <= mis_nxt;
      ph_r  <= ph_nxt;
      st_r  <= st_nxt;
      seq_r <= seq_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ores_r <= ores_nxt;
    if (in_acc && hdr_wr) begin
      hdr_mem_r[pos_r[afv_pkg::HDR_ADDR_W-1:0]] <= in_ch.data_byte;
    end
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.kind         = ores_r.kind;
  assign out_ch.payload_byte = ores_r.payload_byte;
  assign out_ch.field_index  = ores_r.field_index;
  assign out_ch.field_value  = ores_r.field_value;
  assign out_ch.status       = ores_r.status;
  assign out_ch.last         = ores_r.last;

endmodule

`default_nettype wire

>>> tb/sv/afv_tb_pkg.sv
`timescale 1ns / 1ps
// Frame layout constants, the CRC step and the result scoreboard for the frame validator bench.
// Depends on afv_pkg for the result structure, kinds, status codes and field indexes.
package afv_tb_pkg;
  import afv_pkg::*;

  localparam logic [63:0] SIGNATURE = 64'h3146_4954_5241_564B;

  localparam int BASE_LEN = 44;
  localparam int FULL_LEN = 60;

  localparam int OFF_MAJOR   = 8;
  localparam int OFF_MINOR   = 10;
  localparam int OFF_LAYERS  = 12;
  localparam int OFF_CTX     = 16;
  localparam int OFF_TOKENS  = 20;
  localparam int OFF_TYPEK   = 24;
  localparam int OFF_TYPEV   = 26;
  localparam int OFF_FLAGS   = 28;
  localparam int OFF_PAY     = 32;
  localparam int OFF_CRC     = 40;
  localparam int OFF_LASTTOK = 44;
  localparam int OFF_VTRANS  = 48;
  localparam int OFF_MLA     = 49;
  localparam int OFF_RSVD    = 50;
  localparam int OFF_FPRINT  = 52;

  function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    int k;
    r = c;
    for (k = 0; k < 8; k++) begin
      r = (r >> 1) ^ ({32{r[0] ^ b[k]}} & CRC_POLY);
    end
    return r;
  endfunction

  class frame_scoreboard;
    logic [7:0]  hdr [FULL_LEN];
    logic [63:0] pos;
    logic [31:0] crc;
    bit          sig_bad;
    out_res_t    pending [$];
    int          n_errors;
    int          n_results;
    int          by_status [6];

    function new();
      clear();
    endfunction

    function void clear();
      foreach (hdr[i]) hdr[i] = 8'h00;
      pos     = '0;
      crc     = CRC_ONES;
      sig_bad = 1'b0;
    endfunction

    function logic [63:0] le(input int off, input int n);
      logic [63:0] v;
      int i;
      v = '0;
      for (i = 0; i < n; i++) v[8*i +: 8] = hdr[off + i];
      return v;
    endfunction

    function void push(input kind_t k, input logic [7:0] pb, input logic [3:0] idx,
                       input logic [63:0] val, input status_t st, input logic lst);
      out_res_t r;
      r.kind         = k;
      r.payload_byte = pb;
      r.field_index  = idx;
      r.field_value  = val;
      r.status       = st;
      r.last         = lst;
      pending.push_back(r);
    endfunction

    function void note_byte(input logic [7:0] b, input logic eob);
      logic [63:0] p;
      logic [63:0] pay;
      logic [63:0] size;
      logic [63:0] vals [15];
      logic [31:0] want;
      logic [31:0] sum;
      bit          ext;
      int          hsz;
      int          pi;
      int          i;
      status_t     st;
      p = pos;
      if (p < FULL_LEN) begin
        pi = int'(p[5:0]);
        if (pi < BASE_LEN || le(OFF_MINOR, 2) != 0) hdr[pi] = b;
        if (pi < 8 && b != SIGNATURE[8*pi +: 8]) sig_bad = 1'b1;
      end
      ext = le(OFF_MINOR, 2) != 0;
      hsz = ext ? FULL_LEN : BASE_LEN;
      pay = le(OFF_PAY, 8);
      if (p >= hsz && p - hsz < pay) begin
        crc = crc_next(crc, b);
        if (!sig_bad) push(KIND_PAYLOAD, b, 4'd0, '0, ST_OK, 1'b0);
      end
      // saturate at the top of the counter
      if (pos != '1) pos++;
      if (eob) begin
        size = pos;
        want = 32'(le(OFF_CRC, 4));
        if (size < BASE_LEN) st = ST_HDR_SHORT;
        else if (sig_bad) st = ST_BAD_MAGIC;
        else if (ext && size < FULL_LEN) st = ST_EXT_SHORT;
        else if (size - hsz < pay) st = ST_PAY_SHORT;
        else begin
          sum = (pay != 0) ? ~crc : 32'h0;
          st  = (sum != want) ? ST_CRC_BAD : ST_OK;
        end
        if (st == ST_OK) begin
          vals[FLD_MAJOR]    = le(OFF_MAJOR, 2);
          vals[FLD_MINOR]    = le(OFF_MINOR, 2);
          vals[FLD_LAYERS]   = le(OFF_LAYERS, 4);
          vals[FLD_CTX]      = le(OFF_CTX, 4);
          vals[FLD_TOKENS]   = le(OFF_TOKENS, 4);
          vals[FLD_TYPEK]    = le(OFF_TYPEK, 2);
          vals[FLD_TYPEV]    = le(OFF_TYPEV, 2);
          vals[FLD_FLAGS]    = le(OFF_FLAGS, 4);
          vals[FLD_LASTTOK]  = ext ? le(OFF_LASTTOK, 4) : {32'h0, CRC_ONES};
          vals[FLD_VTRANS]   = ext ? le(OFF_VTRANS, 1) : '0;
          vals[FLD_MLA]      = ext ? le(OFF_MLA, 1) : '0;
          vals[FLD_RESERVED] = ext ? le(OFF_RSVD, 2) : '0;
          vals[FLD_FPRINT]   = ext ? le(OFF_FPRINT, 8) : '0;
          vals[FLD_PAYBYTES] = pay;
          vals[FLD_CRC]      = {32'h0, want};
          for (i = int'(FLD_MAJOR); i <= int'(FLD_CRC); i++) begin
            push(KIND_FIELD, 8'h00, 4'(i), vals[i], ST_OK, 1'b0);
          end
        end
        push(KIND_STATUS, 8'h00, 4'd0, '0, st, 1'b1);
        by_status[st]++;
        clear();
      end
    endfunction

    function void cmp(input string name, input logic [63:0] w, input logic [63:0] g);
      if (g !== w) begin
        $error("%s expected %0h got %0h", name, w, g);
        n_errors++;
      end
    endfunction

    function void check_result(input out_res_t got);
      out_res_t w;
      n_results++;
      if (pending.size() == 0) begin
        $error("unexpected result: kind %0d status %0d", got.kind, got.status);
        n_errors++;
        return;
      end
      w = pending.pop_front();
      cmp("kind", w.kind, got.kind);
      cmp("payload_byte", w.payload_byte, got.payload_byte);
      cmp("field_index", w.field_index, got.field_index);
      cmp("field_value", w.field_value, got.field_value);
      cmp("status", w.status, got.status);
      cmp("last", w.last, got.last);
    endfunction
  endclass

endpackage

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// Top of the frame validator bench: clock, reset, buffer stimulus, result handshake and verdict.
// Depends on afv_pkg, afv_tb_pkg, the two channel interfaces and artifact_frame_validator.
module tb;
  import afv_pkg::*;
  import afv_tb_pkg::*;

  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_BYTES = 120;

  typedef enum int {FR_GOOD, FR_JUNK, FR_BADSIG, FR_BADCRC, FR_BIGPAY, FR_NOISE} shape_e;
  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_e;

  logic clk;
  logic rst_n;

  afv_in_if  in_ch();
  afv_out_if out_ch();

  artifact_frame_validator u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  frame_scoreboard sb = new();
  logic [7:0] frame_q [$];
  logic [7:0] img [FULL_LEN];
  out_res_t   seen;
  bit         quiet = 1'b0;
  bit         hold_req = 1'b0;
  int         sent_bytes = 0;
  int         n_frames = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        seen.kind         = kind_t'(out_ch.kind);
        seen.payload_byte = out_ch.payload_byte;
        seen.field_index  = out_ch.field_index;
        seen.field_value  = out_ch.field_value;
        seen.status       = status_t'(out_ch.status);
        seen.last         = out_ch.last;
        sb.check_result(seen);
      end
      if (in_ch.valid && in_ch.ready) sb.note_byte(in_ch.data_byte, in_ch.end_of_buffer);
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    wait (rst_n === 1'b1);
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle = 0;
      else idle++;
    end
    $display("no transaction for %0d cycles, %0d results outstanding",
             IDLE_LIMIT, sb.pending.size());
    $display("artifact_frame_validator: mismatch");
    $finish;
  end

  function automatic logic [63:0] fill_val(input fill_e f);
    logic [63:0] v;
    case (f)
      FILL_ZERO: v = '0;
      FILL_ONES: v = '1;
      default:   v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  function automatic void put_le(input int off, input int n, input logic [63:0] v);
    for (int i = 0; i < n; i++) img[off + i] = v[8*i +: 8];
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eob);
    if (!quiet && $urandom_range(0, 11) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.data_byte     <= b;
    in_ch.end_of_buffer <= eob;
    do @(posedge clk); while (!in_ch.ready);
    sent_bytes++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // keep > 0 cuts a longer buffer to that many bytes; for noise it is the length
  task automatic run_frame(input shape_e shape, input bit ext, input int npay,
                           input fill_e fill, input int keep);
    logic [7:0]  pay_q [$];
    logic [31:0] c;
    logic [63:0] minor;
    int          hlen;
    int          i;
    frame_q = {};
    if (shape == FR_NOISE) begin
      repeat (keep) frame_q.push_back(8'($urandom));
    end else begin
      for (i = 0; i < FULL_LEN; i++) img[i] = 8'(fill_val(fill));
      put_le(0, 8, SIGNATURE);
      minor = fill_val(fill) & 64'hFFFF;
      if (!ext) minor = '0;
      else if (minor == 0 || (fill == FILL_RANDOM && $urandom_range(0, 2) == 0)) minor = 64'd1;
      put_le(OFF_MINOR, 2, minor);
      c = CRC_ONES;
      for (i = 0; i < npay; i++) begin
        pay_q.push_back(8'(fill_val(fill)));
        c = crc_next(c, pay_q[i]);
      end
      put_le(OFF_PAY, 8, 64'(npay));
      put_le(OFF_CRC, 4, npay > 0 ? {32'h0, ~c} : '0);
      case (shape)
        FR_BADSIG: img[$urandom_range(0, 7)] ^= 8'(1 << $urandom_range(0, 7));
        FR_BADCRC: img[OFF_CRC + $urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
        FR_BIGPAY: put_le(OFF_PAY, 8, fill == FILL_ONES ? '1 :
                          64'(npay) + 64'($urandom_range(1, 300)));
        default: ;
      endcase
      hlen = ext ? FULL_LEN : BASE_LEN;
      for (i = 0; i < hlen; i++) frame_q.push_back(img[i]);
      frame_q = {frame_q, pay_q};
      if (shape == FR_JUNK) repeat ($urandom_range(1, 6)) frame_q.push_back(8'($urandom));
      if (keep > 0 && keep < frame_q.size()) frame_q = frame_q[0:keep-1];
    end
    foreach (frame_q[j]) send_byte(frame_q[j], j == frame_q.size() - 1);
    n_frames++;
  endtask

  initial begin
    int     rand_start;
    int     npay;
    int     keep;
    int     pick;
    bit     ext;
    fill_e  fill;
    shape_e shape;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.data_byte     = 8'h00;
    in_ch.end_of_buffer = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_frame(FR_NOISE, 1'b0, 0, FILL_RANDOM, 1);
    run_frame(FR_GOOD, 1'b0, 0, FILL_ZERO, 0);
    // starve the output while a buffer streams in
    hold_req = 1'b1;
    run_frame(FR_GOOD, 1'b1, 3, FILL_ONES, 0);
    wait_drained();
    run_frame(FR_BADCRC, 1'b0, 0, FILL_RANDOM, 0);
    run_frame(FR_BADSIG, 1'b0, 4, FILL_RANDOM, 0);
    run_frame(FR_GOOD, 1'b0, 2, FILL_RANDOM, 43);
    run_frame(FR_GOOD, 1'b1, 2, FILL_RANDOM, 52);
    run_frame(FR_BIGPAY, 1'b0, 2, FILL_ONES, 0);

    rand_start = sent_bytes;
    while (sent_bytes - rand_start < RANDOM_BYTES) begin
      if (sent_bytes - rand_start > RANDOM_BYTES * 3 / 4) quiet = 1'b1;
      ext  = 1'($urandom_range(0, 1));
      npay = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 8);
      fill = FILL_RANDOM;
      if ($urandom_range(0, 9) == 0) fill = $urandom_range(0, 1) ? FILL_ZERO : FILL_ONES;
      keep = 0;
      pick = $urandom_range(0, 99);
      if (pick < 45) shape = FR_GOOD;
      else if (pick < 60) shape = FR_JUNK;
      else if (pick < 70) shape = FR_BADCRC;
      else if (pick < 78) shape = FR_BADSIG;
      else if (pick < 86) shape = FR_BIGPAY;
      else if (pick < 92) begin
        shape = FR_NOISE;
        keep  = $urandom_range(1, 80);
      end else begin
        shape = FR_GOOD;
        keep  = $urandom_range(1, (ext ? FULL_LEN : BASE_LEN) + npay - 1);
      end
      run_frame(shape, ext, npay, fill, keep);
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("covered %0d bytes in %0d buffers, %0d results checked",
             sent_bytes, n_frames, sb.n_results);
    $display("statuses: ok %0d, hdr short %0d, bad sig %0d, ext short %0d, pay short %0d, crc %0d",
             sb.by_status[ST_OK], sb.by_status[ST_HDR_SHORT], sb.by_status[ST_BAD_MAGIC],
             sb.by_status[ST_EXT_SHORT], sb.by_status[ST_PAY_SHORT], sb.by_status[ST_CRC_BAD]);
    if (sb.n_errors == 0) begin
      $display("artifact_frame_validator: match");
    end else begin
      $display("artifact_frame_validator: mismatch");
    end
    $finish;
  end

endmodule
